@@ hw/rtl/vqm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqm_pkg
// Shared types and constants of the voxel quad merger.
// ----------------------------------------------------------------------------
package vqm_pkg;

    localparam int MaxVertices = 4096;
    localparam int AddrW       = $clog2(MaxVertices);
    localparam int CountW      = AddrW + 1;
    localparam int QuadW       = AddrW - 2;

    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdAdd   = 2'd1;
    localparam logic [1:0] CmdRead  = 2'd2;

    localparam logic [2:0] StStaged = 3'd0;
    localparam logic [2:0] StAppend = 3'd1;
    localparam logic [2:0] StMerged = 3'd2;
    localparam logic [2:0] StFull   = 3'd3;
    localparam logic [2:0] StRead   = 3'd4;

    localparam logic [1:0] CfgTile  = 2'd0;
    localparam logic [1:0] CfgStep  = 2'd1;
    localparam logic [1:0] CfgPlane = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [23:0]        normal_bytes;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [15:0]        tex_id;
        logic [31:0]        colour;
        logic [31:0]        terrain_tint;
        logic [11:0]        read_index;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [12:0]        kept_vertices;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [23:0]        out_normal;
        logic signed [15:0] out_u;
        logic signed [15:0] out_v;
        logic [15:0]        out_tex_id;
        logic [31:0]        out_colour;
        logic [31:0]        out_tint;
    } out_word_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [23:0] normal;
        logic [15:0] u;
        logic [15:0] v;
        logic [15:0] tex;
        logic [31:0] colour;
        logic [31:0] tint;
    } vtx_t;

    localparam int VtxW = $bits(vtx_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_WB,
        S_APPEND,
        S_READ,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/voxel_quad_merger.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_quad_merger
// Greedy merging of voxel face quads held in an on-chip vertex store.
//
// A command word is taken when start is high and busy is low. Clear
// empties the store and gives no result. Add stages a vertex; every
// fourth one completes a quad, which is compared against each kept quad
// in order and either stretches the first match, is appended, or is
// dropped when the store is full. Read returns one kept vertex, or
// zero data for an index not below the kept count. Each result word
// appears for one cycle with done high; the receiver cannot stall it.
// A staged vertex passes through S_DONE before its result, and a read
// through S_READ and then S_DONE. For a completed quad the four vertex
// RAMs, one per corner, are read once per kept quad scanned, and
// corners 0, 1 and 3 are written back on a match.
// Configuration writes use cfg_valid, cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high. Reset empties the store at once and loads
// tile_size and cell_step with 16 and plane_mode with 0.
// ----------------------------------------------------------------------------
module voxel_quad_merger (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  vqm_pkg::in_word_t  cmd_word,
    output logic               done,
    output vqm_pkg::out_word_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int QW = vqm_pkg::QuadW;
    localparam int CW = vqm_pkg::CountW;
    localparam int AddrHi = vqm_pkg::AddrW - 1;

    vqm_pkg::state_t    state_reg, state_next;
    logic [15:0]        tile_reg;
    logic [15:0]        step_reg;
    logic               plane_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [1:0]         phase_reg, phase_next;
    logic [QW-1:0]      q_reg, q_next;
    vqm_pkg::in_word_t  cmd_reg;
    vqm_pkg::vtx_t      stage_reg [4];
    vqm_pkg::vtx_t      c_reg [4];
    logic               done_reg, done_next;
    vqm_pkg::out_word_t res_reg, res_next;

    logic [3:0]         we;
    logic [QW-1:0]      addr;
    vqm_pkg::vtx_t      wdata [4];
    vqm_pkg::vtx_t      rdata [4];
    vqm_pkg::vtx_t      in_vtx;
    logic               hit;
    vqm_pkg::vtx_t      w0, w1, w3;
    logic               go;

    assign go = start && !busy;
    assign cfg_ready = 1'b1;
    assign busy = state_reg != vqm_pkg::S_IDLE;
    assign done = done_reg;
    assign result = res_reg;

    always_comb
    begin
        in_vtx.x = cmd_word.pos_x;
        in_vtx.y = cmd_word.pos_y;
        in_vtx.z = cmd_word.pos_z;
        in_vtx.normal = cmd_word.normal_bytes;
        in_vtx.u = cmd_word.tex_u;
        in_vtx.v = cmd_word.tex_v;
        in_vtx.tex = cmd_word.tex_id;
        in_vtx.colour = cmd_word.colour;
        in_vtx.tint = cmd_word.terrain_tint;
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_ram
            vqm_ram #(
                .Width(vqm_pkg::VtxW),
                .Depth(vqm_pkg::MaxVertices / 4)
            ) u_ram (
                .clk  (clk),
                .we   (we[g]),
                .addr (addr),
                .wdata(wdata[g]),
                .rdata(rdata[g])
            );
        end
    endgenerate

    vqm_match u_match (
        .n0(stage_reg[0]), .n1(stage_reg[1]), .n2(stage_reg[2]), .n3(stage_reg[3]),
        .c0(c_reg[0]), .c1(c_reg[1]), .c2(c_reg[2]), .c3(c_reg[3]),
        .tile_size(tile_reg), .cell_step(step_reg), .plane_mode(plane_reg),
        .hit(hit), .w0(w0), .w1(w1), .w3(w3)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vqm_pkg::S_IDLE;
            tile_reg  <= 16'd16;
            step_reg  <= 16'd16;
            plane_reg <= 1'b0;
            count_reg <= '0;
            phase_reg <= '0;
            q_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            q_reg     <= q_next;
            done_reg  <= done_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    vqm_pkg::CfgTile:  tile_reg  <= cfg_data;
                    vqm_pkg::CfgStep:  step_reg  <= cfg_data;
                    vqm_pkg::CfgPlane: plane_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (go)
        begin
            cmd_reg <= cmd_word;
            if (cmd_word.cmd == vqm_pkg::CmdAdd)
            begin
                stage_reg[phase_reg] <= in_vtx;
            end
        end
        if (state_reg == vqm_pkg::S_RD || state_reg == vqm_pkg::S_READ)
        begin
            for (int i = 0; i < 4; i++)
            begin
                c_reg[i] <= rdata[i];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        q_next = q_reg;
        done_next = 1'b0;
        res_next = res_reg;
        we = '0;
        addr = q_reg;
        wdata[0] = w0;
        wdata[1] = w1;
        wdata[2] = c_reg[2];
        wdata[3] = w3;
        unique case (state_reg)
            vqm_pkg::S_IDLE:
            begin
                if (go)
                begin
                    res_next = '0;
                    unique case (cmd_word.cmd)
                        vqm_pkg::CmdClear:
                        begin
                            count_next = '0;
                            phase_next = '0;
                        end
                        vqm_pkg::CmdAdd:
                        begin
                            phase_next = phase_reg + 2'd1;
                            if (phase_reg == 2'd3)
                            begin
                                q_next = '0;
                                addr = q_next;
                                state_next = (count_reg == '0) ? vqm_pkg::S_APPEND
                                    : vqm_pkg::S_RD;
                            end
                            else
                            begin
                                state_next = vqm_pkg::S_DONE;
                            end
                        end
                        vqm_pkg::CmdRead:
                        begin
                            q_next = cmd_word.read_index[AddrHi:2];
                            addr = q_next;
                            state_next = vqm_pkg::S_READ;
                        end
                        default: ;
                    endcase
                end
            end
            vqm_pkg::S_RD:
            begin
                state_next = vqm_pkg::S_CHK;
            end
            vqm_pkg::S_CHK:
            begin
                if (hit)
                begin
                    state_next = vqm_pkg::S_WB;
                end
                else if ({1'b0, q_reg, 2'b00} + CW'(8) > count_reg)
                begin
                    state_next = vqm_pkg::S_APPEND;
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                    addr = q_next;
                    state_next = vqm_pkg::S_RD;
                end
            end
            vqm_pkg::S_WB:
            begin
                we = 4'b1011;
                res_next.status = vqm_pkg::StMerged;
                res_next.kept_vertices = count_reg;
                done_next = 1'b1;
                state_next = vqm_pkg::S_IDLE;
            end
            vqm_pkg::S_APPEND:
            begin
                addr = count_reg[CW-2:2];
                for (int i = 0; i < 4; i++)
                begin
                    wdata[i] = stage_reg[i];
                end
                if (count_reg + CW'(4) > CW'(vqm_pkg::MaxVertices))
                begin
                    res_next.status = vqm_pkg::StFull;
                    res_next.kept_vertices = count_reg;
                end
                else
                begin
                    we = 4'b1111;
                    count_next = count_reg + CW'(4);
                    res_next.status = vqm_pkg::StAppend;
                    res_next.kept_vertices = count_next;
                end
                done_next = 1'b1;
                state_next = vqm_pkg::S_IDLE;
            end
            vqm_pkg::S_READ:
            begin
                state_next = vqm_pkg::S_DONE;
            end
            vqm_pkg::S_DONE:
            begin
                res_next.kept_vertices = count_reg;
                if (cmd_reg.cmd == vqm_pkg::CmdRead)
                begin
                    res_next.status = vqm_pkg::StRead;
                    if ({1'b0, cmd_reg.read_index} < count_reg)
                    begin
                        res_next.out_x      = c_reg[cmd_reg.read_index[1:0]].x;
                        res_next.out_y      = c_reg[cmd_reg.read_index[1:0]].y;
                        res_next.out_z      = c_reg[cmd_reg.read_index[1:0]].z;
                        res_next.out_normal = c_reg[cmd_reg.read_index[1:0]].normal;
                        res_next.out_u      = c_reg[cmd_reg.read_index[1:0]].u;
                        res_next.out_v      = c_reg[cmd_reg.read_index[1:0]].v;
                        res_next.out_tex_id = c_reg[cmd_reg.read_index[1:0]].tex;
                        res_next.out_colour = c_reg[cmd_reg.read_index[1:0]].colour;
                        res_next.out_tint   = c_reg[cmd_reg.read_index[1:0]].tint;
                    end
                end
                else
                begin
                    res_next.status = vqm_pkg::StStaged;
                end
                done_next = 1'b1;
                state_next = vqm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = vqm_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(vqm_pkg::MaxVertices))
        else $error("kept count exceeds store");
    a_count_quads: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[1:0] == 2'b00)
        else $error("kept count not whole quads");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");
    a_wb_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == vqm_pkg::S_WB |-> $past(state_reg) == vqm_pkg::S_CHK)
        else $error("write back without check");
`endif

endmodule

@@ hw/rtl/vqm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqm_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vqm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/vqm_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqm_match
// Face rule check of a staged quad against one kept quad, and the
// stretched vertices to write back on a match.
// ----------------------------------------------------------------------------
module vqm_match (
    input  vqm_pkg::vtx_t  n0,
    input  vqm_pkg::vtx_t  n1,
    input  vqm_pkg::vtx_t  n2,
    input  vqm_pkg::vtx_t  n3,
    input  vqm_pkg::vtx_t  c0,
    input  vqm_pkg::vtx_t  c1,
    input  vqm_pkg::vtx_t  c2,
    input  vqm_pkg::vtx_t  c3,
    input  logic [15:0]    tile_size,
    input  logic [15:0]    cell_step,
    input  logic           plane_mode,
    output logic           hit,
    output vqm_pkg::vtx_t  w0,
    output vqm_pkg::vtx_t  w1,
    output vqm_pkg::vtx_t  w3
);

    logic [16:0] nz_sum;
    logic [16:0] nx_sum;
    logic        z_ok;
    logic        x_ok;
    logic        col_a;
    logic        tint_a;
    logic        pat_b;
    logic        same;
    logic [7:0]  bx;
    logic [7:0]  by;
    logic [7:0]  bz;

    always_comb
    begin
        nz_sum = {n0.z[15], n0.z} + {1'b0, cell_step};
        nx_sum = {n0.x[15], n0.x} + {1'b0, cell_step};
        z_ok = (nz_sum == {c0.z[15], c0.z}) && n0.x == c0.x && n0.y == c0.y;
        x_ok = (nx_sum == {c0.x[15], c0.x}) && n0.y == c0.y && n0.z == c0.z;
        col_a = n2.colour == n3.colour && n0.colour == n1.colour
            && c2.colour == c3.colour && c0.colour == c1.colour
            && n2.colour == c3.colour && n1.colour == c0.colour;
        tint_a = n2.tint == n3.tint && n0.tint == n1.tint
            && n2.tint == c3.tint && n1.tint == c0.tint;
        pat_b = n0.colour == n3.colour && n1.colour == n2.colour
            && c0.colour == c3.colour && c1.colour == c2.colour
            && n0.colour == c3.colour && n1.colour == c2.colour
            && n0.tint == n3.tint && n1.tint == n2.tint
            && n0.tint == c3.tint && n1.tint == c2.tint;
        same = c0.tex == n0.tex && c0.normal == n0.normal;
        bx = c0.normal[7:0];
        by = c0.normal[15:8];
        bz = c0.normal[23:16];
        hit = 1'b0;
        w0 = c0;
        w1 = c1;
        w3 = c3;
        if (plane_mode)
        begin
            hit = c0.normal == 24'h007F00 && n0.normal == 24'h007F00 && z_ok && col_a;
            w0.z = c0.z - cell_step;
            w3.z = c3.z - cell_step;
        end
        else if (by == 8'h7F)
        begin
            hit = same && z_ok && col_a && tint_a;
            w0.z = c0.z - cell_step;
            w3.z = c3.z - cell_step;
            w0.v = c0.v - tile_size;
            w3.v = c3.v - tile_size;
        end
        else if (bx == 8'h7F)
        begin
            hit = same && z_ok && pat_b;
            w0.z = c0.z - cell_step;
            w1.z = c1.z - cell_step;
            w0.u = c0.u - tile_size;
            w1.u = c1.u - tile_size;
        end
        else if (bx == 8'h80)
        begin
            hit = same && z_ok && col_a && tint_a;
            w0.z = c0.z - cell_step;
            w3.z = c3.z - cell_step;
            w0.u = c0.u - tile_size;
            w3.u = c3.u - tile_size;
        end
        else if (bz == 8'h7F)
        begin
            hit = same && x_ok && col_a && tint_a;
            w0.x = c0.x - cell_step;
            w3.x = c3.x - cell_step;
            w0.u = c0.u - tile_size;
            w3.u = c3.u - tile_size;
        end
        else if (bz == 8'h80)
        begin
            hit = same && x_ok && pat_b;
            w0.x = c0.x - cell_step;
            w1.x = c1.x - cell_step;
            w0.u = c0.u - tile_size;
            w1.u = c1.u - tile_size;
        end
    end

endmodule

@@ verif/voxel_quad_merger_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_quad_merger_tb
// Self-checking bench for the voxel quad merger. Command words are driven
// through the start/busy handshake, and a command-level predictor of the
// vertex store works out the status, kept count and read data of every
// result word. Runs cover all face types, plane mode, extreme register
// values, out-of-range reads and coordinate edge cases.
// ----------------------------------------------------------------------------
module voxel_quad_merger_tb;

    localparam logic [1:0]  CmdUnused = 2'd3;
    localparam logic [7:0]  NPos      = 8'h7F;
    localparam logic [7:0]  NNeg      = 8'h80;
    localparam logic [23:0] FaceUp    = 24'h007F00;
    localparam logic [23:0] FaceXPos  = 24'h00007F;
    localparam logic [23:0] FaceXNeg  = 24'h000080;
    localparam logic [23:0] FaceZPos  = 24'h7F0000;
    localparam logic [23:0] FaceZNeg  = 24'h800000;
    localparam int          Limit     = 8000000;
    localparam int          Settle    = 20;

    typedef enum int {UvKeep, UvU, UvV} uv_sel_e;
    typedef vqm_pkg::in_word_t quad_t [4];

    class merge_scoreboard;
        vqm_pkg::vtx_t      verts [vqm_pkg::MaxVertices];
        vqm_pkg::vtx_t      staged [4];
        int unsigned        kept;
        int unsigned        phase;
        logic [15:0]        tile;
        logic [15:0]        step;
        logic               plane;
        vqm_pkg::out_word_t expected_q [$];
        int                 mismatches;

        function new();
            kept = 0;
            phase = 0;
            tile = 16;
            step = 16;
            plane = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                vqm_pkg::CfgTile:  tile = data;
                vqm_pkg::CfgStep:  step = data;
                vqm_pkg::CfgPlane: plane = data[0];
                default:  ;
            endcase
        endfunction

        function bit colours_a(int b, bit with_tint);
            bit ok;
            ok = staged[2].colour == staged[3].colour && staged[0].colour == staged[1].colour
                && verts[b+2].colour == verts[b+3].colour && verts[b].colour == verts[b+1].colour
                && staged[2].colour == verts[b+3].colour && staged[1].colour == verts[b].colour;
            if (with_tint)
            begin
                ok = ok && staged[2].tint == staged[3].tint && staged[0].tint == staged[1].tint
                    && staged[2].tint == verts[b+3].tint && staged[1].tint == verts[b].tint;
            end
            return ok;
        endfunction

        function bit colours_b(int b);
            return staged[0].colour == staged[3].colour && staged[1].colour == staged[2].colour
                && verts[b].colour == verts[b+3].colour
                && verts[b+1].colour == verts[b+2].colour
                && staged[0].colour == verts[b+3].colour
                && staged[1].colour == verts[b+2].colour
                && staged[0].tint == staged[3].tint && staged[1].tint == staged[2].tint
                && staged[0].tint == verts[b+3].tint && staged[1].tint == verts[b+2].tint;
        endfunction

        function bit in_line(int b, bit along_x);
            int s;
            int nx;
            int ny;
            int nz;
            int cx;
            int cy;
            int cz;
            s = int'(step);
            nx = int'($signed(staged[0].x));
            ny = int'($signed(staged[0].y));
            nz = int'($signed(staged[0].z));
            cx = int'($signed(verts[b].x));
            cy = int'($signed(verts[b].y));
            cz = int'($signed(verts[b].z));
            if (along_x)
                return nx + s == cx && ny == cy && nz == cz;
            return nz + s == cz && nx == cx && ny == cy;
        endfunction

        function void stretch(int i, bit on_x, uv_sel_e uv);
            if (on_x)
                verts[i].x = verts[i].x - step;
            else
                verts[i].z = verts[i].z - step;
            if (uv == UvU)
                verts[i].u = verts[i].u - tile;
            else if (uv == UvV)
                verts[i].v = verts[i].v - tile;
        endfunction

        function bit try_merge(int b);
            logic [23:0] nm;
            nm = verts[b].normal;
            if (plane)
            begin
                if (nm != FaceUp || staged[0].normal != FaceUp)
                    return 0;
                if (!in_line(b, 0) || !colours_a(b, 0))
                    return 0;
                stretch(b, 0, UvKeep);
                stretch(b + 3, 0, UvKeep);
                return 1;
            end
            if (verts[b].tex != staged[0].tex || nm != staged[0].normal)
                return 0;
            if (nm[15:8] == NPos)
            begin
                if (!in_line(b, 0) || !colours_a(b, 1))
                    return 0;
                stretch(b, 0, UvV);
                stretch(b + 3, 0, UvV);
            end
            else if (nm[7:0] == NPos)
            begin
                if (!in_line(b, 0) || !colours_b(b))
                    return 0;
                stretch(b, 0, UvU);
                stretch(b + 1, 0, UvU);
            end
            else if (nm[7:0] == NNeg)
            begin
                if (!in_line(b, 0) || !colours_a(b, 1))
                    return 0;
                stretch(b, 0, UvU);
                stretch(b + 3, 0, UvU);
            end
            else if (nm[23:16] == NPos)
            begin
                if (!in_line(b, 1) || !colours_a(b, 1))
                    return 0;
                stretch(b, 1, UvU);
                stretch(b + 3, 1, UvU);
            end
            else if (nm[23:16] == NNeg)
            begin
                if (!in_line(b, 1) || !colours_b(b))
                    return 0;
                stretch(b, 1, UvU);
                stretch(b + 1, 1, UvU);
            end
            else
                return 0;
            return 1;
        endfunction

        function void note_command(vqm_pkg::in_word_t w);
            vqm_pkg::out_word_t e;
            vqm_pkg::vtx_t      r;
            bit                 merged;
            int                 q;
            e = '0;
            case (w.cmd)
                vqm_pkg::CmdClear:
                begin
                    kept = 0;
                    phase = 0;
                    return;
                end
                vqm_pkg::CmdRead:
                begin
                    e.status = vqm_pkg::StRead;
                    if (w.read_index < kept)
                    begin
                        r = verts[w.read_index];
                        e.out_x = r.x;
                        e.out_y = r.y;
                        e.out_z = r.z;
                        e.out_normal = r.normal;
                        e.out_u = r.u;
                        e.out_v = r.v;
                        e.out_tex_id = r.tex;
                        e.out_colour = r.colour;
                        e.out_tint = r.tint;
                    end
                end
                vqm_pkg::CmdAdd:
                begin
                    staged[phase] = '{x: w.pos_x, y: w.pos_y, z: w.pos_z,
                        normal: w.normal_bytes, u: w.tex_u, v: w.tex_v, tex: w.tex_id,
                        colour: w.colour, tint: w.terrain_tint};
                    if (phase != 3)
                    begin
                        phase++;
                        e.status = vqm_pkg::StStaged;
                    end
                    else
                    begin
                        phase = 0;
                        merged = 0;
                        for (q = 0; q + 4 <= kept && !merged; q += 4)
                            merged = try_merge(q);
                        if (merged)
                            e.status = vqm_pkg::StMerged;
                        else if (kept + 4 > vqm_pkg::MaxVertices)
                            e.status = vqm_pkg::StFull;
                        else
                        begin
                            for (q = 0; q < 4; q++)
                                verts[kept + q] = staged[q];
                            kept += 4;
                            e.status = vqm_pkg::StAppend;
                        end
                    end
                end
                default:
                    return;
            endcase
            e.kept_vertices = 13'(kept);
            expected_q.push_back(e);
        endfunction

        function void check_result(vqm_pkg::out_word_t got);
            vqm_pkg::out_word_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.status !== e.status || got.kept_vertices !== e.kept_vertices
                || got.out_x !== e.out_x || got.out_y !== e.out_y || got.out_z !== e.out_z
                || got.out_normal !== e.out_normal || got.out_u !== e.out_u
                || got.out_v !== e.out_v || got.out_tex_id !== e.out_tex_id
                || got.out_colour !== e.out_colour || got.out_tint !== e.out_tint)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    vqm_pkg::in_word_t  cmd_word;
    logic               done;
    vqm_pkg::out_word_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    merge_scoreboard sb;
    int              idle_pct;
    int              cycles;

    voxel_quad_merger DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd_word(cmd_word),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > Limit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic vqm_pkg::in_word_t rand_word();
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(vqm_pkg::in_word_t)-1:0];
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < idle_pct)
            return $urandom_range(1, 5);
        return 0;
    endfunction

    task automatic send_word(vqm_pkg::in_word_t w, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_word <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(w);
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [11:0] idx);
        vqm_pkg::in_word_t w;
        w = rand_word();
        w.cmd = cmd;
        w.read_index = idx;
        send_word(w, pick_gap());
    endtask

    task automatic send_quad(quad_t q);
        int k;
        for (k = 0; k < 4; k++)
            send_word(q[k], pick_gap());
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (Settle) @(posedge clk);
    endtask

    task automatic write_regs(logic [15:0] tile, logic [15:0] step, logic plane);
        logic [15:0] vals [3];
        int k;
        vals[0] = tile;
        vals[1] = step;
        vals[2] = {15'd0, plane};
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(k);
            cfg_data <= vals[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(2'(k), vals[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic make_fresh(output quad_t q, input logic [23:0] nm, input bit wide);
        logic [31:0] col;
        logic [31:0] tint;
        logic [15:0] tex;
        int k;
        col = 32'h1000 + $urandom_range(0, 1);
        tint = 32'h2000 + $urandom_range(0, 1);
        tex = 16'($urandom_range(3, 4));
        for (k = 0; k < 4; k++)
        begin
            q[k] = rand_word();
            q[k].cmd = vqm_pkg::CmdAdd;
            q[k].normal_bytes = nm;
            q[k].tex_id = tex;
            q[k].colour = col;
            q[k].terrain_tint = tint;
            if (!wide)
            begin
                q[k].pos_x = 16'((int'($urandom_range(0, 4)) - 2) * 16);
                q[k].pos_y = 16'(int'($urandom_range(0, 1)) * 16);
                q[k].pos_z = 16'((int'($urandom_range(0, 4)) - 2) * 16);
            end
        end
    endtask

    task automatic make_neighbor(output quad_t q, input int b);
        vqm_pkg::vtx_t c0;
        vqm_pkg::vtx_t c2;
        vqm_pkg::vtx_t c3;
        logic [23:0]   nm;
        bit            on_x;
        bit            pat_b;
        int            k;
        c0 = sb.verts[b];
        c2 = sb.verts[b + 2];
        c3 = sb.verts[b + 3];
        nm = c0.normal;
        on_x = 0;
        pat_b = 0;
        if (!sb.plane && nm[15:8] != NPos)
        begin
            if (nm[7:0] == NPos)
                pat_b = 1;
            else if (nm[7:0] != NNeg)
            begin
                on_x = 1;
                pat_b = nm[23:16] != NPos;
            end
        end
        for (k = 0; k < 4; k++)
        begin
            q[k] = rand_word();
            q[k].cmd = vqm_pkg::CmdAdd;
            q[k].normal_bytes = nm;
            q[k].tex_id = c0.tex;
        end
        q[0].pos_x = on_x ? c0.x - sb.step : c0.x;
        q[0].pos_y = c0.y;
        q[0].pos_z = on_x ? c0.z : c0.z - sb.step;
        if (pat_b)
        begin
            q[0].colour = c3.colour;
            q[3].colour = c3.colour;
            q[1].colour = c2.colour;
            q[2].colour = c2.colour;
            q[0].terrain_tint = c3.tint;
            q[3].terrain_tint = c3.tint;
            q[1].terrain_tint = c2.tint;
            q[2].terrain_tint = c2.tint;
        end
        else
        begin
            q[0].colour = c0.colour;
            q[1].colour = c0.colour;
            q[2].colour = c3.colour;
            q[3].colour = c3.colour;
            q[0].terrain_tint = c0.tint;
            q[1].terrain_tint = c0.tint;
            q[2].terrain_tint = c3.tint;
            q[3].terrain_tint = c3.tint;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, 3);
            q[k].colour[$urandom_range(0, 31)] ^= 1'b1;
        end
    endtask

    task automatic run_phase(int n_items, int pct, bit pause_once);
        quad_t             q;
        vqm_pkg::in_word_t w;
        logic [23:0]       faces [5];
        int                sent;
        int                r;
        bit                paused;
        faces = '{FaceUp, FaceXPos, FaceXNeg, FaceZPos, FaceZNeg};
        idle_pct = pct;
        sent = 0;
        paused = 0;
        while (sent < n_items)
        begin
            if (pause_once && !paused && sent >= n_items / 2)
            begin
                drain();
                paused = 1;
            end
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                send_cmd(vqm_pkg::CmdClear, 12'd0);
                sent++;
            end
            else if (r < 12)
            begin
                if (sb.kept > 0 && $urandom_range(0, 3) != 0)
                    send_cmd(vqm_pkg::CmdRead, 12'($urandom_range(0, sb.kept - 1)));
                else
                    send_cmd(vqm_pkg::CmdRead, 12'($urandom));
                sent++;
            end
            else if (r < 16)
            begin
                w = rand_word();
                send_word(w, pick_gap());
                if (w.cmd != CmdUnused)
                    sent++;
            end
            else
            begin
                if (sb.kept > 0 && $urandom_range(0, 99) < 70)
                    make_neighbor(q, 4 * int'($urandom_range(0, sb.kept / 4 - 1)));
                else if ($urandom_range(0, 99) < 85)
                    make_fresh(q, sb.plane && $urandom_range(0, 1) ? FaceUp
                        : faces[$urandom_range(0, 4)], $urandom_range(0, 99) < 15);
                else
                    make_fresh(q, 24'($urandom), 1);
                send_quad(q);
                sent += 4;
            end
        end
        drain();
    endtask

    task automatic run_directed();
        quad_t q;
        idle_pct = 0;
        send_cmd(CmdUnused, 12'd0);
        send_cmd(vqm_pkg::CmdRead, 12'hFFF);
        make_fresh(q, FaceUp, 0);
        q[0].pos_x = 16'sd0;
        q[0].pos_y = 16'sd0;
        q[0].pos_z = -16'sd32753;
        send_quad(q);
        // Past the top of the range the position sum must not wrap into a match.
        make_neighbor(q, 0);
        q[0].pos_z = 16'sh7FFF;
        send_quad(q);
        make_neighbor(q, 0);
        send_quad(q);
        send_cmd(vqm_pkg::CmdRead, 12'd0);
        send_cmd(vqm_pkg::CmdRead, 12'd3);
        send_cmd(vqm_pkg::CmdClear, 12'd0);
        drain();
    endtask

    initial
    begin
        sb = new();
        idle_pct = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd_word <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= vqm_pkg::CfgTile;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_regs(16'd16, 16'd16, 1'b0);
        run_directed();
        run_phase(95, 0, 0);
        write_regs(16'd0, 16'd1, 1'b0);
        run_phase(95, 61, 1);
        write_regs(16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(95, 29, 0);
        write_regs(16'($urandom), 16'd16, 1'b1);
        run_phase(95, 0, 0);
        write_regs(16'($urandom), 16'($urandom_range(1, 64)), 1'b0);
        run_phase(95, 61, 0);
        write_regs(16'd16, 16'd16, 1'b1);
        run_phase(95, 29, 0);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/vqm_pkg.sv
hw/rtl/vqm_ram.sv
hw/rtl/vqm_match.sv
hw/rtl/voxel_quad_merger.sv
verif/voxel_quad_merger_tb.sv
